@@ hdl/sfs_pkg.sv @@
// Package for the sprite frame sequencer: widths, command and register codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package sfs_pkg;

  localparam int MAX_FRAMES_DEF = 256;
  localparam int TIME_WIDTH_DEF = 16;

  localparam int FRAME_W    = 8;
  localparam int FRAME_LAST = (1 << FRAME_W) - 1;
  localparam int POS_W      = FRAME_W + 1;
  localparam int PERIOD_W   = 16;
  localparam int ELAPSED_W  = 16;
  localparam int ACROSS_W   = 9;
  localparam int PIX_W      = 12;
  localparam int COORD_W    = 20;
  localparam int REQ_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_START  = 3'd1,
    REQ_STOP   = 3'd2,
    REQ_PAUSE  = 3'd3,
    REQ_RESUME = 3'd4
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_PERIOD  = 3'd0,
    REG_RANGE_START   = 3'd1,
    REG_RANGE_END     = 3'd2,
    REG_PING_PONG     = 3'd3,
    REG_LOOP_ENABLE   = 3'd4,
    REG_FRAMES_ACROSS = 3'd5,
    REG_FRAME_WIDTH   = 3'd6,
    REG_FRAME_HEIGHT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_EXEC,
    ST_FRAME,
    ST_DIV,
    ST_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic cfg_write;
    logic capture;
    logic acc;
    logic exec;
    logic frame;
    logic div_step;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } dp_status_t;

  // highest frame index an endpoint may take
  function automatic logic [FRAME_W-1:0] frame_limit(input int max_frames);
    int last;
    last = max_frames - 1;
    if (last > FRAME_LAST) last = FRAME_LAST;
    return FRAME_W'(last);
  endfunction

endpackage

@@ hdl/sfs_ctrl.sv @@
// Controller of the sprite frame sequencer: sequences one request through
// accumulate, update, frame lookup, column/row divide and result load. Uses sfs_pkg.
module sfs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  sfs_pkg::dp_status_t   status,
  output sfs_pkg::ctrl_cmd_t    cmd
);
  import sfs_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cfg_ready     = 1'b1;
        cmd.cfg_write = cfg_valid;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_FRAME;
      end
      ST_FRAME: begin
        cmd.frame  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (!status.out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/sfs_dp.sv @@
// Datapath of the sprite frame sequencer: config registers, accumulator, position,
// frame lookup, restoring divider for column/row, pixel multiply and output register.
// Uses sfs_pkg; driven by sfs_ctrl.
module sfs_dp #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF,
  parameter int TIME_WIDTH = sfs_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sfs_pkg::ctrl_cmd_t               cmd,
  output sfs_pkg::dp_status_t              status,
  input  logic [sfs_pkg::REQ_W-1:0]        req_type,
  input  logic [sfs_pkg::ELAPSED_W-1:0]    elapsed,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [sfs_pkg::FRAME_W-1:0]      frame_index,
  output logic [sfs_pkg::COORD_W-1:0]      frame_x,
  output logic [sfs_pkg::COORD_W-1:0]      frame_y,
  output logic                             is_playing,
  output logic                             done_res
);
  import sfs_pkg::*;

  localparam int AccW = TIME_WIDTH + 1;
  localparam int InW  = (PERIOD_W > ELAPSED_W) ? PERIOD_W : ELAPSED_W;
  localparam int CmpW = (AccW > InW) ? AccW : InW;
  localparam int SumW = CmpW + 1;
  localparam logic [AccW-1:0] AccMax = '1;
  localparam logic [FRAME_W-1:0] ClampMax = frame_limit(MAX_FRAMES);
  localparam int DivCntW = $clog2(FRAME_W);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(FRAME_W - 1);

  // config registers
  logic [PERIOD_W-1:0] frame_period;
  logic [FRAME_W-1:0]  range_start;
  logic [FRAME_W-1:0]  range_end;
  logic                ping_pong;
  logic                loop_enable;
  logic [ACROSS_W-1:0] frames_across;
  logic [PIX_W-1:0]    frame_width;
  logic [PIX_W-1:0]    frame_height;

  // sequencer state
  logic [AccW-1:0]  acc;
  logic [POS_W-1:0] pos;
  logic             playing;
  logic             done_flag;

  // captured request
  logic [REQ_W-1:0]     req_q;
  logic [ELAPSED_W-1:0] elapsed_q;

  // divider
  logic [FRAME_W-1:0] frame_q;
  logic [FRAME_W-1:0] quo;
  logic [FRAME_W-1:0] rem;
  logic [DivCntW-1:0] div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period  <= PERIOD_W'(1);
      range_start   <= '0;
      range_end     <= '0;
      ping_pong     <= 1'b0;
      loop_enable   <= 1'b0;
      frames_across <= ACROSS_W'(1);
      frame_width   <= PIX_W'(1);
      frame_height  <= PIX_W'(1);
    end else if (cmd.cfg_write) begin
      case (cfg_index)
        REG_FRAME_PERIOD:  frame_period  <= cfg_data[PERIOD_W-1:0];
        REG_RANGE_START:   range_start   <= cfg_data[FRAME_W-1:0];
        REG_RANGE_END:     range_end     <= cfg_data[FRAME_W-1:0];
        REG_PING_PONG:     ping_pong     <= cfg_data[0];
        REG_LOOP_ENABLE:   loop_enable   <= cfg_data[0];
        REG_FRAMES_ACROSS: frames_across <= cfg_data[ACROSS_W-1:0];
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[PIX_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // sequence geometry
  logic [FRAME_W-1:0] s_c, e_c, span;
  logic               up, equal;
  logic [POS_W-1:0]   len;

  assign s_c   = (range_start > ClampMax) ? ClampMax : range_start;
  assign e_c   = (range_end > ClampMax) ? ClampMax : range_end;
  assign up    = s_c <= e_c;
  assign span  = up ? e_c - s_c : s_c - e_c;
  assign equal = span == '0;
  assign len   = ping_pong ? {span, 1'b0} : {1'b0, span} + POS_W'(1);

  // endpoints after a range write
  logic               range_write, equal_new;
  logic [FRAME_W-1:0] s_new, e_new, s_new_c, e_new_c;

  assign range_write = (cfg_index == REG_RANGE_START) || (cfg_index == REG_RANGE_END);
  assign s_new   = (cfg_index == REG_RANGE_START) ? cfg_data[FRAME_W-1:0] : range_start;
  assign e_new   = (cfg_index == REG_RANGE_END) ? cfg_data[FRAME_W-1:0] : range_end;
  assign s_new_c = (s_new > ClampMax) ? ClampMax : s_new;
  assign e_new_c = (e_new > ClampMax) ? ClampMax : e_new;
  assign equal_new = s_new_c == e_new_c;

  // accumulator
  logic [SumW-1:0] acc_sum;
  logic [AccW-1:0] acc_sat, acc_sub;
  logic [CmpW-1:0] acc_diff;
  logic            acc_hit, tick;

  assign tick     = req_q == REQ_TICK;
  assign acc_sum  = SumW'(acc) + SumW'(elapsed_q);
  assign acc_sat  = (acc_sum > SumW'(AccMax)) ? AccMax : acc_sum[AccW-1:0];
  assign acc_hit  = CmpW'(acc) >= CmpW'(frame_period);
  assign acc_diff = CmpW'(acc) - CmpW'(frame_period);
  assign acc_sub  = acc_diff[AccW-1:0];

  logic pos_end;
  assign pos_end = ({1'b0, pos} + (POS_W+1)'(1)) >= {1'b0, len};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q     <= req_type;
      elapsed_q <= elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      pos       <= '0;
      playing   <= 1'b0;
      done_flag <= 1'b0;
    end else begin
      if (cmd.cfg_write && range_write && equal_new) begin
        playing <= 1'b0;
        pos     <= '0;
      end
      if (cmd.acc && tick && playing) acc <= acc_sat;
      if (cmd.exec) begin
        done_flag <= 1'b0;
        case (req_q)
          REQ_TICK: begin
            if (playing && acc_hit) begin
              acc <= acc_sub;
              if (pos_end) begin
                if (loop_enable) begin
                  pos <= '0;
                end else begin
                  pos       <= len - POS_W'(1);
                  playing   <= 1'b0;
                  done_flag <= 1'b1;
                end
              end else begin
                pos <= pos + POS_W'(1);
              end
            end
          end
          REQ_START: begin
            if (!equal) begin
              playing <= 1'b1;
              pos     <= '0;
            end
          end
          REQ_STOP: begin
            playing <= 1'b0;
            pos     <= '0;
          end
          REQ_PAUSE:  playing <= 1'b0;
          REQ_RESUME: if (!equal) playing <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // frame index of the current position (ping-pong folds back past the end)
  logic [POS_W-1:0]   len_x, pp, off9;
  logic [FRAME_W-1:0] off, frame_c;

  assign len_x   = (len == '0) ? POS_W'(1) : len;
  assign pp      = (pos >= len_x) ? len_x - POS_W'(1) : pos;
  assign off9    = (pp <= {1'b0, span}) ? pp : {span, 1'b0} - pp;
  assign off     = off9[FRAME_W-1:0];
  assign frame_c = up ? s_c + off : s_c - off;

  // restoring divide by frames_across, one quotient bit per cycle
  logic [ACROSS_W-1:0] across;
  logic [FRAME_W:0]    trial, diff;
  logic                ge;

  assign across = (frames_across == '0) ? ACROSS_W'(1) : frames_across;
  assign trial  = {rem, quo[FRAME_W-1]};
  assign ge     = (FRAME_W+1)'(trial) >= (FRAME_W+1)'(across);
  assign diff   = trial - (FRAME_W+1)'(across);

  always_ff @(posedge clk) begin
    if (cmd.frame) begin
      frame_q <= frame_c;
      quo     <= frame_c;
      rem     <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[FRAME_W-2:0], ge};
      rem <= ge ? diff[FRAME_W-1:0] : trial[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.frame) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DivCntW'(1);
    end
  end

  // pixel coordinates: remainder is the column, quotient the row
  logic [COORD_W-1:0] prod_x, prod_y;
  assign prod_x = COORD_W'(rem) * COORD_W'(frame_width);
  assign prod_y = COORD_W'(quo) * COORD_W'(frame_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_index <= frame_q;
      frame_x     <= prod_x;
      frame_y     <= prod_y;
      is_playing  <= playing;
      done_res    <= done_flag;
    end
  end

  assign status.div_last = div_cnt == DivLast;
  assign status.out_busy = out_valid && !out_ready;

endmodule

@@ hdl/sprite_frame_sequencer.sv @@
// Top level of the sprite frame sequencer: joins controller and datapath.
// Depends on sfs_pkg, sfs_ctrl and sfs_dp.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | in        | in_valid / in_ready  | req_type, elapsed
//  out     | out       | out_valid / out_ready| frame_index, frame_x, frame_y,
//          |           |                      | is_playing, done_res
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request passes from acceptance to the next accept through accumulate, update,
// frame lookup, the bit-per-cycle divider for column and row, then load.
// The result shows in the output register the cycle after load.
// A finished result waits in the output register while the next request is taken;
// load stalls only when that register is still full.
// Synchronous reset clears control state; config registers return to their defaults.
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF,
  parameter int TIME_WIDTH = sfs_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sfs_pkg::REQ_W-1:0]        req_type,
  input  logic [sfs_pkg::ELAPSED_W-1:0]    elapsed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sfs_pkg::FRAME_W-1:0]      frame_index,
  output logic [sfs_pkg::COORD_W-1:0]      frame_x,
  output logic [sfs_pkg::COORD_W-1:0]      frame_y,
  output logic                             is_playing,
  output logic                             done_res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sfs_pkg::*;

  localparam logic [FRAME_W-1:0] ClampMax = frame_limit(MAX_FRAMES);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sfs_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .req_type    (req_type),
    .elapsed     (elapsed),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .frame_index (frame_index),
    .frame_x     (frame_x),
    .frame_y     (frame_y),
    .is_playing  (is_playing),
    .done_res    (done_res)
  );

  // done only ends a run
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !is_playing)
    else $error("done pulse while still playing");

  // shown frame never passes the clamp limit ClampMax
  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_index <= ClampMax)
    else $error("frame index beyond last frame");

  // an accepted request leaves the controller busy: in_ready and cfg_ready both drop
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !cfg_ready)
    else $error("request accepted while busy");

  // a result waiting in the output register holds while the next request is worked on
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_x) && $stable(frame_y))
    else $error("pending result overwritten");

endmodule
